>>> src/key_change_event_emitter_top_defines.svh
// assertion macros used by the key change event emitter checker
`ifndef KEY_CHANGE_EVENT_EMITTER_TOP_DEFINES_SVH
`define KEY_CHANGE_EVENT_EMITTER_TOP_DEFINES_SVH

// same-cycle implication, ignored while reset is high
`define KCEE_CHECK(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, ignored while reset is high
`define KCEE_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define KCEE_CHECK_RAW(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/kcee_pkg.sv
// shared constants and types of the key change event emitter
`default_nettype none

package kcee_pkg;

   // key vector geometry
   localparam int KeyWords  = 4;
   localparam int WordBits  = 32;
   localparam int StoreIdxW = (KeyWords > 1) ? $clog2(KeyWords) : 1;

   // queue between front and back
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // event kinds
   localparam logic [1:0] KindPress   = 2'd0;
   localparam logic [1:0] KindRelease = 2'd1;
   localparam logic [1:0] KindEnd     = 2'd2;

   // work handed from front to back
   typedef struct packed {
      logic [31:0] diff;
      logic [31:0] state_word;
      logic [2:0]  word_index;
      logic        final_word;
      logic [31:0] tick_stamp;
   } kcee_entry_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } kcee_queue_status_type;

endpackage

`default_nettype wire

>>> src/kcee_req_if.sv
// request channel: one key-state word per request
`default_nettype none

interface kcee_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] state_word;
   logic [2:0]  word_index;
   logic        final_word;
   logic        updated;
   logic [31:0] tick_stamp;

   modport source (output valid, output state_word, output word_index,
                   output final_word, output updated, output tick_stamp,
                   input ready);
   modport sink (input valid, input state_word, input word_index,
                 input final_word, input updated, input tick_stamp,
                 output ready);
endinterface

`default_nettype wire

>>> src/kcee_rsp_if.sv
// result channel: one key event per transfer
`default_nettype none

interface kcee_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [7:0]  key_position;
   logic [31:0] event_stamp;
   logic        run_last;

   modport source (output valid, output event_kind, output key_position,
                   output event_stamp, output run_last, input ready);
   modport sink (input valid, input event_kind, input key_position,
                 input event_stamp, input run_last, output ready);
endinterface

`default_nettype wire

>>> src/kcee_front.sv
// front end: accepts words, compares with the committed copy, commits, queues work
`default_nettype none

module kcee_front (
   input  wire                            clock,
   input  wire                            reset,
   kcee_req_if.sink                       req,
   input  kcee_pkg::kcee_queue_status_type status,
   output logic                           push,
   output kcee_pkg::kcee_entry_type       push_entry
);

   logic [31:0] store_ff [kcee_pkg::KeyWords];

   logic                            accept;
   logic                            in_range;
   logic                            compare;
   logic [kcee_pkg::StoreIdxW-1:0]  store_idx;
   logic [31:0]                     diff;

   // classify the incoming word
   assign req.ready = !status.full;
   assign accept    = req.valid && req.ready;
   assign in_range  = ({1'b0, req.word_index} < 4'(kcee_pkg::KeyWords));
   assign compare   = req.updated && in_range;
   assign store_idx = req.word_index[kcee_pkg::StoreIdxW-1:0];
   assign diff      = compare ? (store_ff[store_idx] ^ req.state_word) : 32'd0;

   // only words that cause events go to the back end
   assign push = accept && ((diff != 32'd0) || req.final_word);

   always_comb begin
      push_entry.diff       = diff;
      push_entry.state_word = req.state_word;
      push_entry.word_index = req.word_index;
      push_entry.final_word = req.final_word;
      push_entry.tick_stamp = req.tick_stamp;
   end

   // committed key words, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < kcee_pkg::KeyWords; i++) begin
            store_ff[i] <= 32'd0;
         end
      end else if (accept && compare) begin
         store_ff[store_idx] <= req.state_word;
      end
   end

endmodule

`default_nettype wire

>>> src/kcee_queue.sv
// short queue decoupling the front end from the event generator
`default_nettype none

module kcee_queue (
   input  wire                             clock,
   input  wire                             reset,
   input  logic                            push,
   input  kcee_pkg::kcee_entry_type        push_entry,
   input  logic                            pop,
   output kcee_pkg::kcee_entry_type        head,
   output kcee_pkg::kcee_queue_status_type status
);

   kcee_pkg::kcee_entry_type slot_ff [kcee_pkg::QueueDepth];

   logic [kcee_pkg::QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [kcee_pkg::QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [kcee_pkg::QueueCntW-1:0] count_ff, count_in;

   assign status.full  = (count_ff == kcee_pkg::QueueCntW'(kcee_pkg::QueueDepth));
   assign status.empty = (count_ff == '0);
   assign head         = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         if (wr_ptr_ff == kcee_pkg::QueuePtrW'(kcee_pkg::QueueDepth - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end
      if (pop) begin
         if (rd_ptr_ff == kcee_pkg::QueuePtrW'(kcee_pkg::QueueDepth - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

>>> src/kcee_back.sv
// back end: walks changed bits lowest first and drives one event per cycle while rsp is not stalled
`default_nettype none

module kcee_back (
   input  wire                             clock,
   input  wire                             reset,
   input  kcee_pkg::kcee_entry_type        head,
   input  kcee_pkg::kcee_queue_status_type status,
   output logic                            pop,
   kcee_rsp_if.source                      rsp
);

   // working copy of the current word
   logic        busy_ff, busy_in;
   logic [31:0] diff_ff, diff_in;
   logic [31:0] word_ff, word_in;
   logic [2:0]  widx_ff, widx_in;
   logic        end_ff, end_in;
   logic [31:0] stamp_ff, stamp_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  pos_ff, pos_in;
   logic [31:0] ostamp_ff, ostamp_in;
   logic        last_ff, last_in;

   logic        out_free;
   logic [4:0]  bit_sel;
   logic [31:0] diff_rest;

   function automatic logic [4:0] lowest_bit(input logic [31:0] v);
      logic [4:0] r;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
         if (v[i]) begin
            r = 5'(i);
         end
      end
      return r;
   endfunction

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign pop       = !busy_ff && !status.empty;
   assign bit_sel   = lowest_bit(diff_ff);
   assign diff_rest = diff_ff & (diff_ff - 32'd1);

   // event sequencing
   always_comb begin
      busy_in      = busy_ff;
      diff_in      = diff_ff;
      word_in      = word_ff;
      widx_in      = widx_ff;
      end_in       = end_ff;
      stamp_in     = stamp_ff;
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      pos_in       = pos_ff;
      ostamp_in    = ostamp_ff;
      last_in      = last_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pop) begin
         busy_in  = 1'b1;
         diff_in  = head.diff;
         word_in  = head.state_word;
         widx_in  = head.word_index;
         end_in   = head.final_word;
         stamp_in = head.tick_stamp;
      end else if (busy_ff && out_free) begin
         rsp_valid_in = 1'b1;
         ostamp_in    = stamp_ff;
         if (diff_ff != 32'd0) begin
            // change event at the lowest changed bit
            kind_in = word_ff[bit_sel] ? kcee_pkg::KindPress : kcee_pkg::KindRelease;
            pos_in  = {widx_ff, bit_sel};
            last_in = (diff_rest == 32'd0) && !end_ff;
            diff_in = diff_rest;
            if ((diff_rest == 32'd0) && !end_ff) begin
               busy_in = 1'b0;
            end
         end else begin
            // scan end closes the word
            kind_in = kcee_pkg::KindEnd;
            pos_in  = 8'd0;
            last_in = 1'b1;
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff   <= diff_in;
      word_ff   <= word_in;
      widx_ff   <= widx_in;
      end_ff    <= end_in;
      stamp_ff  <= stamp_in;
      kind_ff   <= kind_in;
      pos_ff    <= pos_in;
      ostamp_ff <= ostamp_in;
      last_ff   <= last_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.event_kind   = kind_ff;
   assign rsp.key_position = pos_ff;
   assign rsp.event_stamp  = ostamp_ff;
   assign rsp.run_last     = last_ff;

endmodule

`default_nettype wire

>>> src/key_change_event_emitter_top.sv
// top level of the key change event emitter
//
//   channel   dir  contents
//   req_chan  in   state_word, word_index, final_word, updated, tick_stamp
//   rsp_chan  out  event_kind, key_position, event_stamp, run_last
//
// a request is taken every cycle while the two-entry queue has room
// each queued word is loaded into the back end and then yields one event per changed bit, lowest first,
// plus a scan end for a final word; the back end emits one event per cycle while rsp_chan is not stalled
// reset clears the committed key words and all control
// a stalled rsp_chan holds its event and the back end; the front keeps filling the queue
`default_nettype none

module key_change_event_emitter_top (
   input  wire        clock,
   input  wire        reset,
   kcee_req_if.sink   req_chan,
   kcee_rsp_if.source rsp_chan
);

   kcee_pkg::kcee_queue_status_type status;
   kcee_pkg::kcee_entry_type        push_entry;
   kcee_pkg::kcee_entry_type        head;
   logic                            push;
   logic                            pop;

   kcee_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .status     (status),
      .push       (push),
      .push_entry (push_entry)
   );

   kcee_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   kcee_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .status (status),
      .pop    (pop),
      .rsp    (rsp_chan)
   );

endmodule

`default_nettype wire

>>> src/kcee_checker.sv
// port-level checker for the key change event emitter and its bind
`default_nettype none

`include "key_change_event_emitter_top_defines.svh"

module kcee_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [1:0]  event_kind,
   input wire [7:0]  key_position,
   input wire [31:0] event_stamp,
   input wire        run_last
);

   // a stalled event stays put
   `KCEE_CHECK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(event_kind) && $stable(key_position) && $stable(event_stamp) && $stable(run_last), "stalled event changed")

   // scan end carries position zero and closes its run
   `KCEE_CHECK(a_end_shape, clock, reset, rsp_valid && (event_kind == kcee_pkg::KindEnd), (key_position == 8'd0) && run_last, "bad scan end event")

   // only defined kinds leave the block
   `KCEE_CHECK(a_kind_code, clock, reset, rsp_valid, (event_kind == kcee_pkg::KindPress) || (event_kind == kcee_pkg::KindRelease) || (event_kind == kcee_pkg::KindEnd), "undefined event kind")

   // no event right after reset
   `KCEE_CHECK_RAW(a_reset_quiet, clock, reset, !rsp_valid, "event valid after reset")

endmodule

bind key_change_event_emitter_top kcee_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .event_kind   (rsp_chan.event_kind),
   .key_position (rsp_chan.key_position),
   .event_stamp  (rsp_chan.event_stamp),
   .run_last     (rsp_chan.run_last)
);

`default_nettype wire
